@@ rtl/gcf_pkg.sv @@
// ----------------------------------------------------------------------------
// gcf_pkg
// Types, widths and constants shared by the gate crossing test blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package gcf_pkg;

   localparam int COORD_BITS     = 16;
   localparam int AXIS_BITS      = 16;
   localparam int AXIS_FRAC_BITS = 14;
   localparam int T_FRAC_BITS    = 16;
   localparam int SIZE_W         = 15;
   localparam int CFG_W          = 3 * AXIS_BITS;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = CFG_W;

   localparam int R_W    = COORD_BITS + 1;
   localparam int PROD_W = R_W + AXIS_BITS;
   localparam int D_W    = PROD_W + 2;
   localparam int DEN_W  = D_W + 1;
   localparam int T_W    = T_FRAC_BITS + 1;
   localparam int MP_W   = T_W + 1 + R_W;
   localparam int PT_W   = MP_W - T_FRAC_BITS + 1;
   localparam int LP_W   = PT_W + AXIS_BITS;
   localparam int L_W    = LP_W + 2;
   localparam int BND_W  = SIZE_W + 2 + AXIS_FRAC_BITS;
   localparam int CMP_W  = (L_W > BND_W) ? L_W : BND_W;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

   localparam logic [CFG_W-1:0]  RST_CENTER = '0;
   localparam logic [CFG_W-1:0]  RST_NORMAL = CFG_W'(48'd16384);
   localparam logic [CFG_W-1:0]  RST_RIGHT  = CFG_W'(48'd1073741824);
   localparam logic [CFG_W-1:0]  RST_UP     = CFG_W'(48'd70368744177664);
   localparam logic [SIZE_W-1:0] RST_HALF   = SIZE_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CENTER      = 3'd0,
      REG_NORMAL      = 3'd1,
      REG_RIGHT       = 3'd2,
      REG_UP          = 3'd3,
      REG_HALF_WIDTH  = 3'd4,
      REG_HALF_HEIGHT = 3'd5,
      REG_THICKNESS   = 3'd6,
      REG_RADIUS      = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [CFG_W-1:0]  center;
      logic [CFG_W-1:0]  normal;
      logic [CFG_W-1:0]  right;
      logic [CFG_W-1:0]  up;
      logic [SIZE_W-1:0] half_w;
      logic [SIZE_W-1:0] half_h;
      logic [SIZE_W-1:0] thick;
      logic [SIZE_W-1:0] radius;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic                  ok;
      logic                  pdir;
      logic                  ge;
      logic [DEN_W-1:0]      num;
      logic [DEN_W-1:0]      den;
      logic [2:0][R_W-1:0]   r0;
      logic [2:0][R_W-1:0]   dl;
   } fe_type;

   typedef struct packed {
      logic                  ok;
      logic                  pdir;
      logic                  ge;
      logic [DEN_W-1:0]      num;
      logic [DEN_W-1:0]      den;
      logic [T_FRAC_BITS-1:0] q;
      logic [2:0][R_W-1:0]   r0;
      logic [2:0][R_W-1:0]   dl;
   } div_type;

endpackage

`default_nettype wire

@@ rtl/gcf_front.sv @@
// ----------------------------------------------------------------------------
// gcf_front
// Plane distances of both positions and classification of the crossing.
// ----------------------------------------------------------------------------
`default_nettype none

module gcf_front (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        en,
   input  wire logic                                        in_valid,
   input  wire logic [2:0][gcf_pkg::COORD_BITS-1:0]         p0,
   input  wire logic [2:0][gcf_pkg::COORD_BITS-1:0]         p1,
   input  wire gcf_pkg::cfg_type                            cfg,
   output logic                                             out_valid,
   output gcf_pkg::fe_type                                  out_item
);

   logic                                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0][gcf_pkg::R_W-1:0]          r0_ff, r1_ff, dl_ff;
   logic [2:0][gcf_pkg::R_W-1:0]          r0b_ff, dlb_ff, r0c_ff, dlc_ff;
   logic [2:0][gcf_pkg::PROD_W-1:0]       m0_ff, m1_ff;
   logic signed [gcf_pkg::D_W-1:0]        d0_ff, d1_ff;
   gcf_pkg::fe_type                       item_ff;

   logic [2:0][gcf_pkg::R_W-1:0]          r0_in, r1_in, dl_in;
   logic [2:0][gcf_pkg::PROD_W-1:0]       m0_in, m1_in;
   logic signed [gcf_pkg::D_W-1:0]        d0_in, d1_in;
   gcf_pkg::fe_type                       item_in;

   function automatic logic [gcf_pkg::DEN_W-1:0] DEN_W_NEG(
      input logic signed [gcf_pkg::DEN_W-1:0] v);
      return gcf_pkg::DEN_W'(-v);
   endfunction

   always_comb begin
      logic signed [gcf_pkg::R_W-1:0]    a, b, c;
      logic signed [gcf_pkg::PROD_W-1:0] pa, pb;
      logic signed [gcf_pkg::DEN_W-1:0]  e0, e1, dn;
      for (int i = 0; i < 3; i++) begin
         a = gcf_pkg::R_W'($signed(p0[i]));
         b = gcf_pkg::R_W'($signed(p1[i]));
         c = gcf_pkg::R_W'($signed(cfg.center[gcf_pkg::AXIS_BITS*i +: gcf_pkg::AXIS_BITS]));
         r0_in[i] = a - c;
         r1_in[i] = b - c;
         dl_in[i] = b - a;
         pa = gcf_pkg::PROD_W'($signed(r0_ff[i])) *
              gcf_pkg::PROD_W'($signed(cfg.normal[gcf_pkg::AXIS_BITS*i +: gcf_pkg::AXIS_BITS]));
         pb = gcf_pkg::PROD_W'($signed(r1_ff[i])) *
              gcf_pkg::PROD_W'($signed(cfg.normal[gcf_pkg::AXIS_BITS*i +: gcf_pkg::AXIS_BITS]));
         m0_in[i] = pa;
         m1_in[i] = pb;
      end
      d0_in = gcf_pkg::D_W'($signed(m0_ff[0])) + gcf_pkg::D_W'($signed(m0_ff[1])) +
              gcf_pkg::D_W'($signed(m0_ff[2]));
      d1_in = gcf_pkg::D_W'($signed(m1_ff[0])) + gcf_pkg::D_W'($signed(m1_ff[1])) +
              gcf_pkg::D_W'($signed(m1_ff[2]));
      e0 = gcf_pkg::DEN_W'(d0_ff);
      e1 = gcf_pkg::DEN_W'(d1_ff);
      dn = e1 - e0;
      item_in.num  = (e0 < 0) ? DEN_W_NEG(e0) : e0;
      item_in.den  = (dn < 0) ? DEN_W_NEG(dn) : dn;
      item_in.ge   = item_in.num >= item_in.den;
      item_in.ok   = !((d0_ff == 0) && (d1_ff == 0)) &&
                     !((d0_ff > 0) && (d1_ff > 0)) &&
                     !((d0_ff < 0) && (d1_ff < 0)) && (dn != 0);
      item_in.pdir = (d0_ff < 0) && (d1_ff >= 0);
      item_in.r0   = r0c_ff;
      item_in.dl   = dlc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff   <= r0_in;
         r1_ff   <= r1_in;
         dl_ff   <= dl_in;
         m0_ff   <= m0_in;
         m1_ff   <= m1_in;
         r0b_ff  <= r0_ff;
         dlb_ff  <= dl_ff;
         d0_ff   <= d0_in;
         d1_ff   <= d1_in;
         r0c_ff  <= r0b_ff;
         dlc_ff  <= dlb_ff;
         item_ff <= item_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

@@ rtl/gcf_fifo.sv @@
// ----------------------------------------------------------------------------
// gcf_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gcf_fifo (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire gcf_pkg::fe_type push_item,
   input  wire logic            pop,
   output logic                 full,
   output logic                 empty,
   output gcf_pkg::fe_type      head
);

   gcf_pkg::fe_type                mem_ff [0:gcf_pkg::FIFO_DEPTH-1];
   logic [gcf_pkg::FIFO_AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [gcf_pkg::FIFO_AW:0]      cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign full  = cnt_ff == (gcf_pkg::FIFO_AW+1)'(gcf_pkg::FIFO_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rd_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("item pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("item popped from empty queue");
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (gcf_pkg::FIFO_AW'(wr_ff - rd_ff) == gcf_pkg::FIFO_AW'(cnt_ff)))
      else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

@@ rtl/gcf_back.sv @@
// ----------------------------------------------------------------------------
// gcf_back
// Pipelined divide for t, interpolation, projection and box tests.
// ----------------------------------------------------------------------------
`default_nettype none

module gcf_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire gcf_pkg::fe_type in_item,
   input  wire gcf_pkg::cfg_type cfg,
   output logic                 out_valid,
   output logic                 passed,
   output logic                 hit
);

   localparam int NS = gcf_pkg::T_FRAC_BITS;

   gcf_pkg::div_type                  div_ff [0:NS];
   logic                              dv_ff  [0:NS];
   gcf_pkg::div_type                  div_in [1:NS];

   logic                              vm_ff, vp_ff, vl_ff, vs_ff, vo_ff;
   logic                              okm_ff, okp_ff, okl_ff, oks_ff;
   logic                              pdm_ff, pdp_ff, pdl_ff, pds_ff;
   logic [2:0][gcf_pkg::MP_W-1:0]     mp_ff, mp_in;
   logic [2:0][gcf_pkg::R_W-1:0]      r0m_ff;
   logic [2:0][gcf_pkg::PT_W-1:0]     pt_ff, pt_in;
   logic [2:0][gcf_pkg::LP_W-1:0]     lx_p_ff, ly_p_ff, lx_p_in, ly_p_in;
   logic signed [gcf_pkg::L_W-1:0]    lx_ff, ly_ff, lx_in, ly_in;
   logic                              passed_ff, hit_ff, passed_in, hit_in;

   always_comb begin
      logic [gcf_pkg::DEN_W:0] sh;
      for (int k = 1; k <= NS; k++) begin
         div_in[k] = div_ff[k-1];
         sh = {div_ff[k-1].num, 1'b0};
         if (sh >= {1'b0, div_ff[k-1].den}) begin
            div_in[k].num = gcf_pkg::DEN_W'(sh - {1'b0, div_ff[k-1].den});
            div_in[k].q   = {div_ff[k-1].q[NS-2:0], 1'b1};
         end else begin
            div_in[k].num = gcf_pkg::DEN_W'(sh);
            div_in[k].q   = {div_ff[k-1].q[NS-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic [gcf_pkg::T_W-1:0]          t;
      logic signed [gcf_pkg::T_W:0]     ts;
      logic signed [gcf_pkg::MP_W-1:0]  pr, st;
      logic signed [gcf_pkg::PT_W-1:0]  s;
      logic signed [gcf_pkg::LP_W-1:0]  qa, qb;
      t  = div_ff[NS].ge ? gcf_pkg::T_ONE : {1'b0, div_ff[NS].q};
      ts = $signed({1'b0, t});
      for (int i = 0; i < 3; i++) begin
         pr = gcf_pkg::MP_W'(ts) * gcf_pkg::MP_W'($signed(div_ff[NS].dl[i]));
         mp_in[i] = pr;
         st = $signed(mp_ff[i]) + gcf_pkg::MP_W'(1 << (gcf_pkg::T_FRAC_BITS - 1));
         s  = gcf_pkg::PT_W'(st >>> gcf_pkg::T_FRAC_BITS);
         pt_in[i] = s + gcf_pkg::PT_W'($signed(r0m_ff[i]));
         qa = gcf_pkg::LP_W'($signed(pt_ff[i])) *
              gcf_pkg::LP_W'($signed(cfg.right[gcf_pkg::AXIS_BITS*i +: gcf_pkg::AXIS_BITS]));
         qb = gcf_pkg::LP_W'($signed(pt_ff[i])) *
              gcf_pkg::LP_W'($signed(cfg.up[gcf_pkg::AXIS_BITS*i +: gcf_pkg::AXIS_BITS]));
         lx_p_in[i] = qa;
         ly_p_in[i] = qb;
      end
      lx_in = gcf_pkg::L_W'($signed(lx_p_ff[0])) + gcf_pkg::L_W'($signed(lx_p_ff[1])) +
              gcf_pkg::L_W'($signed(lx_p_ff[2]));
      ly_in = gcf_pkg::L_W'($signed(ly_p_ff[0])) + gcf_pkg::L_W'($signed(ly_p_ff[1])) +
              gcf_pkg::L_W'($signed(ly_p_ff[2]));
   end

   always_comb begin
      logic [gcf_pkg::SIZE_W-1:0]  iw, ih;
      logic [gcf_pkg::SIZE_W+1:0]  ow, oh;
      logic [gcf_pkg::CMP_W-1:0]   ax, ay, biw, bih, bow, boh;
      logic                        in_i, in_o;
      iw = (cfg.half_w > cfg.radius) ? cfg.half_w - cfg.radius : '0;
      ih = (cfg.half_h > cfg.radius) ? cfg.half_h - cfg.radius : '0;
      ow = (gcf_pkg::SIZE_W+2)'(cfg.half_w) + cfg.thick + cfg.radius;
      oh = (gcf_pkg::SIZE_W+2)'(cfg.half_h) + cfg.thick + cfg.radius;
      ax = gcf_pkg::CMP_W'(lx_ff < 0 ? gcf_pkg::L_W'(-lx_ff) : gcf_pkg::L_W'(lx_ff));
      ay = gcf_pkg::CMP_W'(ly_ff < 0 ? gcf_pkg::L_W'(-ly_ff) : gcf_pkg::L_W'(ly_ff));
      biw = gcf_pkg::CMP_W'(iw) << gcf_pkg::AXIS_FRAC_BITS;
      bih = gcf_pkg::CMP_W'(ih) << gcf_pkg::AXIS_FRAC_BITS;
      bow = gcf_pkg::CMP_W'(ow) << gcf_pkg::AXIS_FRAC_BITS;
      boh = gcf_pkg::CMP_W'(oh) << gcf_pkg::AXIS_FRAC_BITS;
      in_i = (ax <= biw) && (ay <= bih);
      in_o = (ax <= bow) && (ay <= boh);
      passed_in = oks_ff && pds_ff && in_i;
      hit_in    = oks_ff && in_o && !in_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NS; k++) begin
            dv_ff[k] <= 1'b0;
         end
         vm_ff <= 1'b0;
         vp_ff <= 1'b0;
         vl_ff <= 1'b0;
         vs_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= in_valid;
         for (int k = 1; k <= NS; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         vm_ff <= dv_ff[NS];
         vp_ff <= vm_ff;
         vl_ff <= vp_ff;
         vs_ff <= vl_ff;
         vo_ff <= vs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0].ok   <= in_item.ok;
         div_ff[0].pdir <= in_item.pdir;
         div_ff[0].ge   <= in_item.ge;
         div_ff[0].num  <= in_item.num;
         div_ff[0].den  <= in_item.den;
         div_ff[0].q    <= '0;
         div_ff[0].r0   <= in_item.r0;
         div_ff[0].dl   <= in_item.dl;
         for (int k = 1; k <= NS; k++) begin
            div_ff[k] <= div_in[k];
         end
         mp_ff     <= mp_in;
         r0m_ff    <= div_ff[NS].r0;
         okm_ff    <= div_ff[NS].ok;
         pdm_ff    <= div_ff[NS].pdir;
         pt_ff     <= pt_in;
         okp_ff    <= okm_ff;
         pdp_ff    <= pdm_ff;
         lx_p_ff   <= lx_p_in;
         ly_p_ff   <= ly_p_in;
         okl_ff    <= okp_ff;
         pdl_ff    <= pdp_ff;
         lx_ff     <= lx_in;
         ly_ff     <= ly_in;
         oks_ff    <= okl_ff;
         pds_ff    <= pdl_ff;
         passed_ff <= passed_in;
         hit_ff    <= hit_in;
      end
   end

   assign out_valid = vo_ff;
   assign passed    = passed_ff;
   assign hit       = hit_ff;

endmodule

`default_nettype wire

@@ rtl/gate_crossing_and_frame_hit_test.sv @@
// ----------------------------------------------------------------------------
// gate_crossing_and_frame_hit_test
// Segment against gate plane: pass through opening, or hit on frame band.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  prev_x..z, curr_x..z
//   rsp      out        rsp_valid/rsp_ready  passed, frame_hit
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One item per cycle sustained while the queue has room and rsp_ready
// is not holding the back; t comes from the 16-step pipelined divider.
// Synchronous reset clears valids and loads register defaults.
// The front stalls only when the queue is full; the back stalls on rsp_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module gate_crossing_and_frame_hit_test (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [gcf_pkg::COORD_BITS-1:0]    req_prev_x,
   input  wire logic [gcf_pkg::COORD_BITS-1:0]    req_prev_y,
   input  wire logic [gcf_pkg::COORD_BITS-1:0]    req_prev_z,
   input  wire logic [gcf_pkg::COORD_BITS-1:0]    req_curr_x,
   input  wire logic [gcf_pkg::COORD_BITS-1:0]    req_curr_y,
   input  wire logic [gcf_pkg::COORD_BITS-1:0]    req_curr_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_passed,
   output logic                                   rsp_frame_hit,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [gcf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [gcf_pkg::CSR_DATA_W-1:0]    csr_data
);

   gcf_pkg::cfg_type  cfg_ff, cfg_in;
   logic              fe_en, fe_valid, be_en, q_full, q_empty, q_push, q_pop;
   gcf_pkg::fe_type   fe_item, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (gcf_pkg::reg_idx_type'(csr_index))
            gcf_pkg::REG_CENTER:      cfg_in.center = csr_data;
            gcf_pkg::REG_NORMAL:      cfg_in.normal = csr_data;
            gcf_pkg::REG_RIGHT:       cfg_in.right  = csr_data;
            gcf_pkg::REG_UP:          cfg_in.up     = csr_data;
            gcf_pkg::REG_HALF_WIDTH:  cfg_in.half_w = csr_data[gcf_pkg::SIZE_W-1:0];
            gcf_pkg::REG_HALF_HEIGHT: cfg_in.half_h = csr_data[gcf_pkg::SIZE_W-1:0];
            gcf_pkg::REG_THICKNESS:   cfg_in.thick  = csr_data[gcf_pkg::SIZE_W-1:0];
            gcf_pkg::REG_RADIUS:      cfg_in.radius = csr_data[gcf_pkg::SIZE_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center <= gcf_pkg::RST_CENTER;
         cfg_ff.normal <= gcf_pkg::RST_NORMAL;
         cfg_ff.right  <= gcf_pkg::RST_RIGHT;
         cfg_ff.up     <= gcf_pkg::RST_UP;
         cfg_ff.half_w <= gcf_pkg::RST_HALF;
         cfg_ff.half_h <= gcf_pkg::RST_HALF;
         cfg_ff.thick  <= '0;
         cfg_ff.radius <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   assign fe_en     = !(fe_valid && q_full);
   assign req_ready = fe_en;
   assign q_push    = fe_valid && !q_full;
   assign be_en     = !rsp_valid || rsp_ready;
   assign q_pop     = be_en && !q_empty;

   gcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (fe_en),
      .in_valid  (req_valid),
      .p0        ({req_prev_z, req_prev_y, req_prev_x}),
      .p1        ({req_curr_z, req_curr_y, req_curr_x}),
      .cfg       (cfg_ff),
      .out_valid (fe_valid),
      .out_item  (fe_item)
   );

   gcf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (fe_item),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   gcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (be_en),
      .in_valid  (!q_empty),
      .in_item   (q_head),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .passed    (rsp_passed),
      .hit       (rsp_frame_hit)
   );

endmodule

`default_nettype wire
